[hdl/lss_pkg.sv]
package lss_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 5;

	// capacity after reset
	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_PEEK   = 2'd2,
		MODE_SEARCH = 2'd3
	} mode_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // latch the incoming transaction
		logic push;        // write value at top, bump count
		logic reject;      // result: ok = 0, data = 0
		logic rd_top;      // read address = count - 1
		logic take_top;    // capture read data, pop decrements count
		logic scan_start;  // read entry 0, clear result
		logic scan;        // compare one entry, read the next
		logic emit;        // load the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		mode_t mode;
		logic  empty;
		logic  can_push;
		logic  hit;
		logic  last;
	} status_t;

endpackage

[hdl/lss_ram.sv]
module lss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/lss_datapath.sv]
module lss_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lss_pkg::cmd_t                 cmd,
	output lss_pkg::status_t              status,
	input  logic                          cfg_we,
	input  logic [lss_pkg::CNT_W-1:0]     cfg_data,
	input  logic [1:0]                    mode,
	input  logic signed [lss_pkg::DATA_W-1:0] value,
	output logic                          ok,
	output logic signed [lss_pkg::DATA_W-1:0] data_out,
	output logic [lss_pkg::CNT_W-1:0]     entry_count,
	output logic                          is_empty_flag,
	output logic                          is_full_flag
);

	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// count never exceeds the 5-bit capacity, so cap the limit there too
	localparam int LIM_MAX = (DEPTH > 31) ? 31 : DEPTH;
	localparam logic [lss_pkg::CNT_W-1:0] DEPTH_LIM = lss_pkg::CNT_W'(LIM_MAX);
	localparam logic [lss_pkg::CNT_W-1:0] CNT_ONE   = lss_pkg::CNT_W'(1);

	logic [lss_pkg::CNT_W-1:0]  capacity_q;
	logic [lss_pkg::CNT_W-1:0]  count_q;
	logic [lss_pkg::CNT_W-1:0]  scan_idx_q;
	lss_pkg::mode_t             mode_q;
	logic [lss_pkg::DATA_W-1:0] value_q;
	logic                       res_ok_q;
	logic [lss_pkg::DATA_W-1:0] res_data_q;

	logic [lss_pkg::CNT_W-1:0]  limit;
	logic [lss_pkg::CNT_W-1:0]  count_dec;
	logic [AW-1:0]              waddr;
	logic [AW-1:0]              raddr;
	logic [lss_pkg::DATA_W-1:0] rdata;

	function automatic logic [AW-1:0] to_addr(input logic [lss_pkg::CNT_W-1:0] c);
		logic [31:0] ext;
		ext = 32'(c);
		return ext[AW-1:0];
	endfunction

	assign limit     = (32'(capacity_q) > 32'(DEPTH)) ? DEPTH_LIM : capacity_q;
	assign count_dec = count_q - CNT_ONE;
	assign waddr     = to_addr(count_q);

	always_comb begin
		raddr = to_addr(scan_idx_q);
		if (cmd.rd_top) begin
			raddr = to_addr(count_dec);
		end else if (cmd.scan_start) begin
			raddr = '0;
		end
	end

	lss_ram #(
		.WIDTH(lss_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(waddr),
		.wdata(value_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign status.mode     = mode_q;
	assign status.empty    = (count_q == '0);
	assign status.can_push = (count_q < limit);
	assign status.hit      = (rdata == value_q);
	assign status.last     = (scan_idx_q == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lss_pkg::CAP_RESET;
			count_q    <= '0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_data;
			end
			if (cmd.push) begin
				count_q <= count_q + CNT_ONE;
			end else if (cmd.take_top && mode_q == lss_pkg::MODE_POP) begin
				count_q <= count_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= lss_pkg::mode_t'(mode);
			value_q <= value;
		end
		if (cmd.push) begin
			res_ok_q   <= 1'b1;
			res_data_q <= '0;
		end
		if (cmd.reject) begin
			res_ok_q   <= 1'b0;
			res_data_q <= '0;
		end
		if (cmd.take_top) begin
			res_ok_q   <= 1'b1;
			res_data_q <= rdata;
		end
		if (cmd.scan_start) begin
			res_ok_q   <= 1'b0;
			res_data_q <= '0;
			scan_idx_q <= CNT_ONE;
		end
		if (cmd.scan) begin
			res_ok_q   <= status.hit;
			scan_idx_q <= scan_idx_q + CNT_ONE;
		end
		if (cmd.emit) begin
			ok            <= res_ok_q;
			data_out      <= res_data_q;
			entry_count   <= count_q;
			is_empty_flag <= (count_q == '0);
			is_full_flag  <= (count_q >= limit);
		end
	end

endmodule

[hdl/lss_ctrl.sv]
module lss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  lss_pkg::status_t status,
	output lss_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RDWAIT,
		S_SCAN,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FIN;
				case (status.mode)
					lss_pkg::MODE_PUSH: begin
						if (status.can_push) begin
							cmd.push = 1'b1;
						end else begin
							cmd.reject = 1'b1;
						end
					end
					lss_pkg::MODE_POP, lss_pkg::MODE_PEEK: begin
						if (status.empty) begin
							cmd.reject = 1'b1;
						end else begin
							cmd.rd_top = 1'b1;
							state_d    = S_RDWAIT;
						end
					end
					lss_pkg::MODE_SEARCH: begin
						if (status.empty) begin
							cmd.reject = 1'b1;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					default: begin
						cmd.reject = 1'b1;
					end
				endcase
			end
			S_RDWAIT: begin
				cmd.take_top = 1'b1;
				state_d      = S_FIN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (status.hit || status.last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.emit | (out_valid_q & out_stall);
		end
	end

endmodule

[hdl/lifo_stack_with_search.sv]
// LIFO stack of signed 32-bit words, DEPTH entries deep, with a capacity
// register (0..31, 16 after reset; values above DEPTH act as DEPTH, zero
// makes every push fail). Each input transaction carries one operation in
// mode: push, pop, peek or search, and yields exactly one result transaction
// with ok, the word read (zero unless a pop or peek succeeded), the entry
// count after the operation and the empty/full flags. Items are handled one
// at a time by a small sequencer around a single-port-read RAM with a
// registered read: after acceptance an item is decoded, pop and peek
// wait for the RAM read, search compares entries from the bottom up to
// the first match or to the top (one RAM read per cycle), then the result
// is registered; empty-stack pop, peek and search go straight from decode
// to the result. The input reopens as soon as the result is in the output
// register, so the next transaction can be accepted while that result is
// still stalled. Capacity is written through the cfg channel, which is
// always ready; write it only while the block is idle.
module lifo_stack_with_search #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lss_pkg::CNT_W-1:0]         capacity,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        mode,
	input  logic signed [lss_pkg::DATA_W-1:0] value,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              ok,
	output logic signed [lss_pkg::DATA_W-1:0] data_out,
	output logic [lss_pkg::CNT_W-1:0]         entry_count,
	output logic                              is_empty_flag,
	output logic                              is_full_flag
);

	lss_pkg::cmd_t    cmd;
	lss_pkg::status_t status;

	// the capacity register takes a write every cycle
	assign cfg_ready = 1'b1;

	// sequencer: owns the input and result handshakes and the output valid
	lss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// storage, count, capacity, search compare and the result registers
	lss_datapath #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_data     (capacity),
		.mode         (mode),
		.value        (value),
		.ok           (ok),
		.data_out     (data_out),
		.entry_count  (entry_count),
		.is_empty_flag(is_empty_flag),
		.is_full_flag (is_full_flag)
	);

endmodule

[hdl/lss_checker.sv]
module lss_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              ok,
	input logic signed [lss_pkg::DATA_W-1:0] data_out,
	input logic [lss_pkg::CNT_W-1:0]         entry_count,
	input logic                              is_empty_flag
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(data_out) && $stable(entry_count) && $stable(ok))
		else $error("result changed while stalled");

	// empty flag agrees with the count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty_flag == (entry_count == '0)))
		else $error("empty flag does not match entry count");

	// a failed operation reports no data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> data_out == '0)
		else $error("data on a failed operation");

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.ok           (ok),
	.data_out     (data_out),
	.entry_count  (entry_count),
	.is_empty_flag(is_empty_flag)
);

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int STACK_DEPTH = 16;
	// cycles without any accepted transaction before the run is declared hung
	localparam int WATCHDOG_LIMIT = 5000;
	// drain margin at the end: a full-depth search plus the pipeline
	localparam int TAIL_CYCLES = 30;
	localparam logic signed [lss_pkg::DATA_W-1:0] ALL_ONES = -1;
	localparam logic signed [lss_pkg::DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [lss_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

	// one result transaction as it should leave the block
	typedef struct packed {
		logic                              ok;
		logic signed [lss_pkg::DATA_W-1:0] data;
		logic [lss_pkg::CNT_W-1:0]         count;
		logic                              empty;
		logic                              full;
	} stack_result_t;

	logic                              clk;
	logic                              arst_n = 1'b0;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [lss_pkg::CNT_W-1:0]         capacity = lss_pkg::CAP_RESET;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [1:0]                        mode = lss_pkg::MODE_PUSH;
	logic signed [lss_pkg::DATA_W-1:0] value = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic                              ok;
	logic signed [lss_pkg::DATA_W-1:0] data_out;
	logic [lss_pkg::CNT_W-1:0]         entry_count;
	logic                              is_empty_flag;
	logic                              is_full_flag;

	// shadow of the stack contents, fill level and capacity register
	logic signed [lss_pkg::DATA_W-1:0] stack_mem [STACK_DEPTH];
	int                                stack_fill = 0;
	logic [lss_pkg::CNT_W-1:0]         cap_shadow = lss_pkg::CAP_RESET;

	// results still owed by the block, oldest first
	stack_result_t                     pending_results[$];

	int                                mismatch_count = 0;
	int                                send_gap_pct = 0;
	int                                recv_stall_pct = 0;
	int                                idle_cycles = 0;

	lifo_stack_with_search #(
		.DEPTH(STACK_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.capacity     (capacity),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ok           (ok),
		.data_out     (data_out),
		.entry_count  (entry_count),
		.is_empty_flag(is_empty_flag),
		.is_full_flag (is_full_flag)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Applies one operation to the shadow stack and returns the result the
	// block has to produce. Capacity above the depth acts as the depth;
	// capacity zero means full, so every push bounces.
	function automatic stack_result_t apply_stack_op(lss_pkg::mode_t op,
			logic signed [lss_pkg::DATA_W-1:0] word);
		stack_result_t r;
		int            eff_cap;
		r = '0;
		eff_cap = (cap_shadow > STACK_DEPTH) ? STACK_DEPTH : int'(cap_shadow);
		case (op)
			lss_pkg::MODE_PUSH: begin
				if (stack_fill < eff_cap) begin
					stack_mem[stack_fill] = word;
					stack_fill++;
					r.ok = 1'b1;
				end
			end
			lss_pkg::MODE_POP: begin
				if (stack_fill > 0) begin
					stack_fill--;
					r.data = stack_mem[stack_fill];
					r.ok = 1'b1;
				end
			end
			lss_pkg::MODE_PEEK: begin
				if (stack_fill > 0) begin
					r.data = stack_mem[stack_fill - 1];
					r.ok = 1'b1;
				end
			end
			default: begin
				// search only looks at occupied entries
				for (int i = 0; i < stack_fill; i++)
					if (stack_mem[i] == word)
						r.ok = 1'b1;
			end
		endcase
		r.count = lss_pkg::CNT_W'(stack_fill);
		r.empty = (stack_fill == 0);
		r.full  = (stack_fill >= eff_cap);
		return r;
	endfunction

	// Random word biased toward the extremes and toward small values, so that
	// duplicates show up and searches hit more than one candidate.
	function automatic logic signed [lss_pkg::DATA_W-1:0] pick_word();
		case ($urandom_range(5))
			0:       return WORD_MAX;
			1:       return WORD_MIN;
			2:       return ALL_ONES;
			3:       return lss_pkg::DATA_W'($urandom_range(7));
			default: return $urandom;
		endcase
	endfunction

	// Mostly legal capacities, with zero and above-depth settings mixed in.
	function automatic logic [lss_pkg::CNT_W-1:0] pick_capacity();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return lss_pkg::CNT_W'($urandom_range(STACK_DEPTH + 1, 30));
			3:       return lss_pkg::CNT_W'(STACK_DEPTH);
			4:       return lss_pkg::CNT_W'(1);
			default: return lss_pkg::CNT_W'($urandom_range(1, STACK_DEPTH));
		endcase
	endfunction

	// Sends one input transaction. Called right after a rising edge; valid is
	// left high on return so back-to-back items need no extra NBA on it.
	task automatic send_op(lss_pkg::mode_t op, logic signed [lss_pkg::DATA_W-1:0] word);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= op;
		value    <= word;
		do
			@(posedge clk);
		while (in_stall);
		// accepted at this edge: the result it owes goes to the back of the line
		pending_results.push_back(apply_stack_op(op, word));
	endtask

	// Holds the input off until the block has returned every result. Always
	// spends at least one edge, so the caller's next drive lands in a new step.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// Capacity may only change while the block is idle. Every item yields a
	// result, so an empty line means nothing is in flight.
	task automatic write_capacity(logic [lss_pkg::CNT_W-1:0] cap);
		wait_drained();
		cfg_valid <= 1'b1;
		capacity  <= cap;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid  <= 1'b0;
		cap_shadow  = cap;
	endtask

	// Pop, peek and search right out of reset, all on an empty stack.
	task automatic test_empty_stack();
		send_op(lss_pkg::MODE_POP, WORD_MAX);
		send_op(lss_pkg::MODE_PEEK, WORD_MIN);
		send_op(lss_pkg::MODE_SEARCH, '0);
	endtask

	// Extreme words through push, search, peek and pop; drains the stack.
	task automatic test_word_extremes();
		send_op(lss_pkg::MODE_PUSH, WORD_MAX);
		send_op(lss_pkg::MODE_PUSH, WORD_MIN);
		send_op(lss_pkg::MODE_PUSH, '0);
		send_op(lss_pkg::MODE_PUSH, ALL_ONES);
		send_op(lss_pkg::MODE_SEARCH, ALL_ONES);
		send_op(lss_pkg::MODE_SEARCH, 32'sd1);
		send_op(lss_pkg::MODE_PEEK, '0);
		repeat (4)
			send_op(lss_pkg::MODE_POP, '0);
	endtask

	// Full stack, capacity dropped under the fill level, zero capacity and a
	// capacity above the built depth.
	task automatic test_capacity_edges();
		write_capacity(lss_pkg::CNT_W'(2));
		send_op(lss_pkg::MODE_PUSH, 32'sd11);
		send_op(lss_pkg::MODE_PUSH, 32'sd22);
		send_op(lss_pkg::MODE_PUSH, 32'sd33);   // bounces, stack full
		write_capacity(lss_pkg::CNT_W'(1));
		send_op(lss_pkg::MODE_PUSH, 32'sd44);   // bounces, fill above capacity
		send_op(lss_pkg::MODE_POP, '0);
		send_op(lss_pkg::MODE_POP, '0);
		write_capacity('0);
		send_op(lss_pkg::MODE_PUSH, 32'sd55);   // zero capacity: always full
		send_op(lss_pkg::MODE_SEARCH, 32'sd55);
		write_capacity('1);
		send_op(lss_pkg::MODE_PUSH, 32'sd66);
		send_op(lss_pkg::MODE_POP, '0);
	endtask

	// Segments of random traffic, each with its own capacity and a bias toward
	// filling, emptying or neither, so both the full and the empty corners get visited.
	task automatic test_random_traffic(int gap_pct, int stall_pct, int n_items);
		int                                sent;
		int                                push_pct;
		lss_pkg::mode_t                    op;
		logic signed [lss_pkg::DATA_W-1:0] word;
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			write_capacity(pick_capacity());
			case ($urandom_range(2))
				0:       push_pct = 70;
				1:       push_pct = 30;
				default: push_pct = 50;
			endcase
			repeat ($urandom_range(20, 80)) begin
				if ($urandom_range(99) < push_pct)
					op = lss_pkg::MODE_PUSH;
				else begin
					case ($urandom_range(3))
						0, 1:    op = lss_pkg::MODE_POP;
						2:       op = lss_pkg::MODE_PEEK;
						default: op = lss_pkg::MODE_SEARCH;
					endcase
				end
				// searches mostly ask for a word that is actually stored
				if (op == lss_pkg::MODE_SEARCH && stack_fill > 0 && $urandom_range(9) < 6)
					word = stack_mem[$urandom_range(stack_fill - 1)];
				else
					word = pick_word();
				send_op(op, word);
				sent++;
				// now and then hold the input until the block is empty-handed
				if ($urandom_range(49) == 0)
					wait_drained();
			end
		end
	endtask

	// Result side: random stall, and a field-by-field compare of every
	// accepted result against the oldest outstanding prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with nothing outstanding");
					mismatch_count++;
				end else begin
					stack_result_t exp_r;
					exp_r = pending_results.pop_front();
					if (ok !== exp_r.ok) begin
						$error("ok: expected %0d, got %0d", exp_r.ok, ok);
						mismatch_count++;
					end
					if (data_out !== exp_r.data) begin
						$error("data_out: expected %0d, got %0d", exp_r.data, data_out);
						mismatch_count++;
					end
					if (entry_count !== exp_r.count) begin
						$error("entry_count: expected %0d, got %0d", exp_r.count,
							entry_count);
						mismatch_count++;
					end
					if (is_empty_flag !== exp_r.empty) begin
						$error("is_empty_flag: expected %0d, got %0d", exp_r.empty,
							is_empty_flag);
						mismatch_count++;
					end
					if (is_full_flag !== exp_r.full) begin
						$error("is_full_flag: expected %0d, got %0d", exp_r.full,
							is_full_flag);
						mismatch_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: any accepted transaction on any channel resets the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_stack();
		test_word_extremes();
		test_capacity_edges();

		// sender gaps light, receiver stalls heavy; then swapped; then none
		test_random_traffic(17, 69, 450);
		test_random_traffic(69, 17, 450);
		test_random_traffic(0, 0, 450);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
